[src/trit_pkg.sv]
// ----------------------------------------------------------------------------
// trit_pkg
// Shared widths, codes and types for the trickle interval timer.
// ----------------------------------------------------------------------------
package trit_pkg;

    // time base width for interval, elapsed and fire point
    localparam int TW      = 36;
    localparam int CNT_W   = $clog2(TW);
    localparam int FUNC_W  = 3;
    localparam int HEARD_W = 8;

    // configuration register widths
    localparam int IMIN_W  = 16;
    localparam int DBL_W   = 5;
    localparam int RED_W   = 8;
    localparam int SHIFT_W = IMIN_W + (1 << DBL_W) - 1;

    // apb port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TW-1:0] TMASK = {TW{1'b1}};

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK         = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONSISTENT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INCONSISTENT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_START        = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP         = 3'd4;

    // register indexes (word address)
    localparam logic [1:0] REG_MIN_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_MAX_DOUBLINGS = 2'd1;
    localparam logic [1:0] REG_REDUNDANCY    = 2'd2;

    // reset values of the configuration registers
    localparam logic [IMIN_W-1:0] IMIN_RST = 16'd8;
    localparam logic [DBL_W-1:0]  DBL_RST  = 5'd20;
    localparam logic [RED_W-1:0]  RED_RST  = 8'd10;

    localparam logic [HEARD_W-1:0] HEARD_MAX = {HEARD_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DRAW_I,
        ST_HALF,
        ST_DRAW_T,
        ST_DONE
    } trit_state_t;

    // status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

[src/trit_if.sv]
// ----------------------------------------------------------------------------
// trit_if
// Valid/ready channel interfaces for timer items and results.
// ----------------------------------------------------------------------------
interface trit_item_if import trit_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TW-1:0]     rand_interval;
    logic [TW-1:0]     rand_point;

    modport source (output valid, func, rand_interval, rand_point, input ready);
    modport sink   (input valid, func, rand_interval, rand_point, output ready);
endinterface

interface trit_result_if import trit_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               transmit;
    logic               interval_started;
    logic [TW-1:0]      interval_ticks;
    logic [HEARD_W-1:0] heard_count;
    logic               running;

    modport source (output valid, transmit, interval_started, interval_ticks,
                    heard_count, running, input ready);
    modport sink   (input valid, transmit, interval_started, interval_ticks,
                    heard_count, running, output ready);
endinterface

[src/trit_rem.sv]
// ----------------------------------------------------------------------------
// trit_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module trit_rem import trit_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW-1:0] dividend,
    input  logic [TW-1:0] divisor,
    output logic [TW-1:0] remainder,
    output rem_status_t   status
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(TW - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TW-1:0]    dvd_reg, dvd_next;
    logic [TW-1:0]    dsr_reg, dsr_next;
    logic [TW-1:0]    rem_reg, rem_next;

    logic [TW:0]      shifted;
    logic [TW+1:0]    diff;

    // trial subtract of the divisor from the partial remainder
    assign shifted = {rem_reg, dvd_reg[TW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TW-2:0], 1'b0};
            rem_next = diff[TW+1] ? shifted[TW-1:0] : diff[TW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[src/trickle_interval_timer.sv]
// ----------------------------------------------------------------------------
// trickle_interval_timer
// Trickle timer advanced by one item a transaction, with apb configuration.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  item      in         valid/ready     func, rand_interval, rand_point
//  result    out        valid/ready     transmit, interval_started,
//                                       interval_ticks, heard_count, running
//  apb       in         psel/penable    min_interval, max_doublings,
//                                       redundancy
//
//  one item at a time; ready only while the sequencer is idle
//  plain items just dispatch; an interval-ending tick or an inconsistent
//  reset draws a fire point, a start an interval first; each draw of a
//  random value modulo a span is 36 steps of the shared remainder unit
//  reset: timer stopped, interval 0, registers at 8 / 20 / 10
//  a stalled result holds the sequencer in its last state; the next item
//  can be taken while the finished result waits
// ----------------------------------------------------------------------------
module trickle_interval_timer import trit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    trit_item_if.sink          item,
    trit_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration registers
    logic [IMIN_W-1:0] min_interval_reg;
    logic [DBL_W-1:0]  max_doublings_reg;
    logic [RED_W-1:0]  redundancy_reg;

    // derived interval limits
    logic [TW-1:0]      lo_reg, lo_next;
    logic [TW-1:0]      hi_reg, hi_next;
    logic [IMIN_W-1:0]  imin;
    logic [SHIFT_W-1:0] imax_wide;

    // sequencer and timer state
    trit_state_t        state_reg, state_next;
    logic               active_reg, active_next;
    logic [TW-1:0]      interval_reg, interval_next;
    logic [TW-1:0]      elapsed_reg, elapsed_next;
    logic [TW-1:0]      fire_reg, fire_next;
    logic [HEARD_W-1:0] heard_reg, heard_next;
    logic               tx_reg, tx_next;
    logic               started_reg, started_next;

    // latched item
    logic [FUNC_W-1:0]  func_reg;
    logic [TW-1:0]      rand_interval_reg;
    logic [TW-1:0]      rand_point_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               out_tx_reg;
    logic               out_started_reg;
    logic [TW-1:0]      out_interval_reg;
    logic [HEARD_W-1:0] out_heard_reg;
    logic               out_running_reg;
    logic               out_load;
    logic               out_free;

    // remainder unit
    logic               rem_start;
    logic [TW-1:0]      rem_dividend;
    logic [TW-1:0]      rem_divisor;
    logic [TW-1:0]      rem_value;
    rem_status_t        rem_status;

    // datapath helpers
    logic [TW-1:0]      elapsed_inc;
    logic [TW:0]        doubled;
    logic [TW-1:0]      half;
    logic [TW-1:0]      span_pt;
    logic               item_take;
    logic               cfg_write;

    assign item_take = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;

    // apb access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= IMIN_RST;
            max_doublings_reg <= DBL_RST;
            redundancy_reg    <= RED_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MIN_INTERVAL:  min_interval_reg  <= pwdata[IMIN_W-1:0];
                REG_MAX_DOUBLINGS: max_doublings_reg <= pwdata[DBL_W-1:0];
                REG_REDUNDANCY:    redundancy_reg    <= pwdata[RED_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_INTERVAL:  prdata = PDATA_W'(min_interval_reg);
            REG_MAX_DOUBLINGS: prdata = PDATA_W'(max_doublings_reg);
            REG_REDUNDANCY:    prdata = PDATA_W'(redundancy_reg);
            default:           prdata = '0;
        endcase
    end

    // interval limits, zero minimum taken as one, maximum saturated
    assign imin      = (min_interval_reg == '0) ? IMIN_W'(1) : min_interval_reg;
    assign imax_wide = SHIFT_W'(imin) << max_doublings_reg;
    assign lo_next   = TW'(imin);
    assign hi_next   = (|imax_wide[SHIFT_W-1:TW]) ? TMASK : imax_wide[TW-1:0];

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // shared remainder unit
    trit_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .remainder (rem_value),
        .status    (rem_status)
    );

    assign elapsed_inc = elapsed_reg + 1'b1;
    assign doubled     = {interval_reg, 1'b0};
    assign half        = interval_reg >> 1;
    assign span_pt     = (interval_reg == half) ? TW'(1) : interval_reg - half;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (item_take)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                case (func_reg)
                    FUNC_START:
                        state_next = ST_DRAW_I;
                    FUNC_TICK:
                        if (active_reg && elapsed_inc >= interval_reg)
                            state_next = ST_HALF;
                        else
                            state_next = ST_DONE;
                    FUNC_INCONSISTENT:
                        if (active_reg && interval_reg != lo_reg)
                            state_next = ST_HALF;
                        else
                            state_next = ST_DONE;
                    default:
                        state_next = ST_DONE;
                endcase
            ST_DRAW_I:
                if (rem_status.done)
                    state_next = ST_HALF;
            ST_HALF:
                state_next = ST_DRAW_T;
            ST_DRAW_T:
                if (rem_status.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath updates and outputs per state
    always_comb
    begin
        active_next    = active_reg;
        interval_next  = interval_reg;
        elapsed_next   = elapsed_reg;
        fire_next      = fire_reg;
        heard_next     = heard_reg;
        tx_next        = tx_reg;
        started_next   = started_reg;
        rem_start      = 1'b0;
        rem_dividend   = rand_point_reg;
        rem_divisor    = span_pt;
        out_load       = 1'b0;
        item.ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                item.ready = 1'b1;
            ST_DISPATCH:
            begin
                tx_next      = 1'b0;
                started_next = 1'b0;
                case (func_reg)
                    FUNC_START:
                    begin
                        rem_start    = 1'b1;
                        rem_dividend = rand_interval_reg;
                        rem_divisor  = hi_reg - lo_reg + 1'b1;
                        active_next  = 1'b1;
                    end
                    FUNC_STOP:
                    begin
                        active_next  = 1'b0;
                        elapsed_next = '0;
                    end
                    FUNC_TICK:
                        if (active_reg)
                        begin
                            tx_next = (elapsed_reg == fire_reg) &&
                                      (redundancy_reg == '0 ||
                                       heard_reg < HEARD_W'(redundancy_reg));
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc >= interval_reg)
                                interval_next = (doubled > {1'b0, hi_reg}) ?
                                                hi_reg : doubled[TW-1:0];
                        end
                    FUNC_CONSISTENT:
                        if (active_reg && heard_reg != HEARD_MAX)
                            heard_next = heard_reg + 1'b1;
                    FUNC_INCONSISTENT:
                        if (active_reg && interval_reg != lo_reg)
                            interval_next = lo_reg;
                    default:
                        ;
                endcase
            end
            ST_DRAW_I:
                if (rem_status.done)
                    interval_next = lo_reg + rem_value;
            ST_HALF:
                rem_start = 1'b1;
            ST_DRAW_T:
                if (rem_status.done)
                begin
                    fire_next    = half + rem_value;
                    elapsed_next = '0;
                    heard_next   = '0;
                    started_next = 1'b1;
                end
            ST_DONE:
                out_load = out_free;
            default:
                ;
        endcase
    end

    // result valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            interval_reg  <= '0;
            elapsed_reg   <= '0;
            fire_reg      <= '0;
            heard_reg     <= '0;
            tx_reg        <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            interval_reg  <= interval_next;
            elapsed_reg   <= elapsed_next;
            fire_reg      <= fire_next;
            heard_reg     <= heard_next;
            tx_reg        <= tx_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            func_reg          <= item.func;
            rand_interval_reg <= item.rand_interval;
            rand_point_reg    <= item.rand_point;
        end
        if (out_load)
        begin
            out_tx_reg       <= tx_reg;
            out_started_reg  <= started_reg;
            out_interval_reg <= interval_reg;
            out_heard_reg    <= heard_reg;
            out_running_reg  <= active_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.transmit         = out_tx_reg;
    assign result.interval_started = out_started_reg;
    assign result.interval_ticks   = out_interval_reg;
    assign result.heard_count      = out_heard_reg;
    assign result.running          = out_running_reg;

endmodule
